// ===== rtl/bcm_pkg.sv =====
// Shared types and constants for the banked cartridge mapper with scanline IRQ.
package bcm_pkg;

	// Bus item kinds carried on the op field.
	typedef enum logic [2:0] {
		OP_CPU_RD = 3'd0,
		OP_CPU_WR = 3'd1,
		OP_PPU_RD = 3'd2,
		OP_PPU_WR = 3'd3,
		OP_TICK   = 3'd4
	} op_t;

	// Memory selected by a result.
	typedef enum logic [2:0] {
		TGT_NONE    = 3'd0,
		TGT_PRG_RAM = 3'd1,
		TGT_PRG_ROM = 3'd2,
		TGT_CHR     = 3'd3,
		TGT_REG     = 3'd4
	} target_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PRG_BANK_COUNT   = 2'd0;
	localparam logic [1:0] CFG_CHR_IS_RAM       = 2'd1;
	localparam logic [1:0] CFG_MIRRORING_DISABLED = 2'd2;

	// Mirroring codes.
	localparam logic [1:0] MIRRORING_NONE = 2'd2;

	// CPU address map.
	localparam logic [15:0] RAM_BASE = 16'h6000;
	localparam logic [15:0] ROM_BASE = 16'h8000;

	// Widths of the external interfaces.
	localparam int ADDR_W   = 16;
	localparam int MAPPED_W = 19;
	localparam int CFG_W    = 7;

endpackage

// ===== rtl/banked_cartridge_mapper_irq.sv =====
// Top level of the banked cartridge mapper: address translation, registers and scanline IRQ.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------------
//  in      | input     | in_valid / in_stall  | op, address, value
//  out     | output    | out_valid / out_stall| target, mapped_address, write_enable,
//          |           |                      | write_data, irq, mirroring
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// An item is captured in the input stage and its result is then registered in the result
// register, so one item is accepted every cycle unless in_stall is raised.
// Translation and the register and IRQ counter updates happen as the item moves from
// the input stage into the result register; a held result holds the input stage, and
// the input stalls only once that stage is full as well.
// Reset clears the valid flags, the bank and IRQ state and loads the default configuration.
module banked_cartridge_mapper_irq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    op,
	input  logic [bcm_pkg::ADDR_W-1:0]    address,
	input  logic [7:0]                    value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    target,
	output logic [bcm_pkg::MAPPED_W-1:0]  mapped_address,
	output logic                          write_enable,
	output logic [7:0]                    write_data,
	output logic                          irq,
	output logic [1:0]                    mirroring,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [bcm_pkg::CFG_W-1:0]     cfg_data
);
	import bcm_pkg::*;

	// Configuration registers.
	logic [6:0] prg_bank_count_q;
	logic       chr_is_ram_q;
	logic       mirroring_disabled_q;

	// Mapper state.
	logic [7:0] bank_select_q;
	logic [7:0] bank_regs_q [8];
	logic       mirror_bit_q;
	logic [7:0] irq_latch_q;
	logic [7:0] irq_count_q;
	logic       irq_reload_q;
	logic       irq_enable_q;

	// Input stage.
	logic                valid_s1;
	logic [2:0]          op_s1;
	logic [ADDR_W-1:0]   address_s1;
	logic [7:0]          value_s1;

	// Result register.
	logic                valid_s2;
	target_t             target_s2;
	logic [MAPPED_W-1:0] mapped_s2;
	logic                we_s2;
	logic [7:0]          wdata_s2;
	logic                irq_s2;
	logic [1:0]          mirroring_s2;

	// Handshake.
	logic advance_s1;
	logic take_in;

	// Combinational results of the item in the input stage.
	target_t             target_c;
	logic [MAPPED_W-1:0] mapped_c;
	logic                we_c;
	logic [7:0]          wdata_c;
	logic                irq_c;
	logic                reg_wr_c;
	logic                tick_c;
	logic [7:0]          count_next_c;
	logic                mirror_next_c;
	logic [MAPPED_W-1:0] prg_mapped_c;
	logic [MAPPED_W-1:0] chr_mapped_c;

	// Stage control: the input stage moves on whenever the result register is free.
	assign advance_s1 = ~valid_s2 | ~out_stall;
	assign in_stall   = valid_s1 & ~advance_s1;
	assign take_in    = in_valid & ~in_stall;

	// PRG ROM window translation.
	always_comb begin
		logic [5:0] last_bank;
		logic [5:0] second_bank;
		logic [5:0] r6;
		logic [5:0] bank;
		last_bank   = 6'(prg_bank_count_q - 7'd1);
		second_bank = 6'(prg_bank_count_q - 7'd2);
		r6          = bank_regs_q[6][5:0];
		unique case (address_s1[14:13])
			2'd0: begin
				bank = bank_select_q[6] ? second_bank : r6;
			end
			2'd1: begin
				bank = bank_regs_q[7][5:0];
			end
			2'd2: begin
				bank = bank_select_q[6] ? r6 : second_bank;
			end
			default: begin
				bank = last_bank;
			end
		endcase
		prg_mapped_c = {bank, address_s1[12:0]};
	end

	// CHR window translation; bit 7 of the select swaps the two pattern halves.
	always_comb begin
		logic [2:0] win;
		logic [7:0] reg_val;
		logic [7:0] bank;
		win     = address_s1[12:10] ^ {bank_select_q[7], 2'b00};
		reg_val = bank_regs_q[{2'b00, win[1]}];
		if (!win[2]) begin
			bank = win[0] ? (reg_val | 8'h01) : (reg_val & 8'hFE);
		end else begin
			bank = bank_regs_q[3'd2 + {1'b0, win[1:0]}];
		end
		chr_mapped_c = {1'b0, bank, address_s1[9:0]};
	end

	// Per-item decode of target, address and write.
	always_comb begin
		target_c = TGT_NONE;
		mapped_c = '0;
		we_c     = 1'b0;
		wdata_c  = 8'h00;
		reg_wr_c = 1'b0;
		tick_c   = 1'b0;
		unique case (op_s1)
			OP_CPU_RD, OP_CPU_WR: begin
				if (address_s1 < RAM_BASE) begin
					target_c = TGT_NONE;
				end else if (address_s1 < ROM_BASE) begin
					target_c = TGT_PRG_RAM;
					mapped_c = {6'd0, address_s1[12:0]};
					if (op_s1 == OP_CPU_WR) begin
						we_c    = 1'b1;
						wdata_c = value_s1;
					end
				end else if (op_s1 == OP_CPU_RD) begin
					target_c = TGT_PRG_ROM;
					mapped_c = prg_mapped_c;
				end else begin
					target_c = TGT_REG;
					mapped_c = {3'd0, address_s1};
					reg_wr_c = 1'b1;
				end
			end
			OP_PPU_RD, OP_PPU_WR: begin
				target_c = TGT_CHR;
				mapped_c = chr_mapped_c;
				if (op_s1 == OP_PPU_WR && chr_is_ram_q) begin
					we_c    = 1'b1;
					wdata_c = value_s1;
				end
			end
			OP_TICK: begin
				tick_c = 1'b1;
			end
			default: begin
				target_c = TGT_NONE;
			end
		endcase
	end

	// Scanline counter: reload on zero or on request, else count down.
	always_comb begin
		if (irq_count_q == 8'd0 || irq_reload_q) begin
			count_next_c = irq_latch_q;
		end else begin
			count_next_c = irq_count_q - 8'd1;
		end
		irq_c = tick_c & (count_next_c == 8'd0) & irq_enable_q;
	end

	// Mirroring as it stands after this item.
	assign mirror_next_c = (reg_wr_c && address_s1[14:13] == 2'd1 && !address_s1[0]) ?
		value_s1[0] : mirror_bit_q;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1      <= op;
			address_s1 <= address;
			value_s1   <= value;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && valid_s1) begin
			target_s2    <= target_c;
			mapped_s2    <= mapped_c;
			we_s2        <= we_c;
			wdata_s2     <= wdata_c;
			irq_s2       <= irq_c;
			mirroring_s2 <= mirroring_disabled_q ? MIRRORING_NONE : {1'b0, mirror_next_c};
		end
	end

	// Mapper state updates, committed as an item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q <= 8'h00;
			for (int i = 0; i < 8; i++) begin
				bank_regs_q[i] <= 8'h00;
			end
			mirror_bit_q  <= 1'b0;
			irq_latch_q   <= 8'h00;
			irq_count_q   <= 8'h00;
			irq_reload_q  <= 1'b0;
			irq_enable_q  <= 1'b0;
		end else if (advance_s1 && valid_s1) begin
			mirror_bit_q <= mirror_next_c;
			if (tick_c) begin
				irq_count_q  <= count_next_c;
				irq_reload_q <= 1'b0;
			end
			if (reg_wr_c) begin
				unique case (address_s1[14:13])
					2'd0: begin
						if (address_s1[0]) begin
							bank_regs_q[bank_select_q[2:0]] <= value_s1;
						end else begin
							bank_select_q <= value_s1;
						end
					end
					2'd1: begin
						// Mirroring handled above; the odd register (RAM protect) is ignored.
					end
					2'd2: begin
						if (address_s1[0]) begin
							irq_reload_q <= 1'b1;
						end else begin
							irq_latch_q <= value_s1;
						end
					end
					default: begin
						irq_enable_q <= address_s1[0];
					end
				endcase
			end
		end
	end

	// Configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_count_q     <= 7'd32;
			chr_is_ram_q         <= 1'b0;
			mirroring_disabled_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRG_BANK_COUNT: begin
					prg_bank_count_q <= cfg_data;
				end
				CFG_CHR_IS_RAM: begin
					chr_is_ram_q <= cfg_data[0];
				end
				CFG_MIRRORING_DISABLED: begin
					mirroring_disabled_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Output ports.
	assign out_valid      = valid_s2;
	assign target         = target_s2;
	assign mapped_address = mapped_s2;
	assign write_enable   = we_s2;
	assign write_data     = wdata_s2;
	assign irq            = irq_s2;
	assign mirroring      = mirroring_s2;

	// A memory write only ever goes to PRG RAM or CHR.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && we_s2 |-> target_s2 == TGT_PRG_RAM || target_s2 == TGT_CHR)
		else $error("write enable on a target that is not writable memory");

	// An IRQ pulse belongs to a scanline tick, which has no target and no address.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && irq_s2 |-> target_s2 == TGT_NONE && mapped_s2 == '0 && !we_s2)
		else $error("irq raised on a result that is not a scanline tick");

	// The input side stalls only while a held result blocks a full input stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a blocked pipeline");

	// An item moving on from a full input stage must show up as a result the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance_s1 |=> valid_s2)
		else $error("item lost between input stage and result register");

endmodule

// ===== dv/banked_cartridge_mapper_irq_tb.sv =====
// Self-checking testbench for the banked cartridge mapper with scanline IRQ.
`timescale 1ns / 100ps

module banked_cartridge_mapper_irq_tb;
	import bcm_pkg::*;

	localparam int NUM_PHASES   = 7;
	localparam int RANDOM_ITEMS = 1600;
	localparam int SMOKE_ROWS   = 26;
	localparam int LONG_HOLD    = 300;

	localparam logic [1:0] MIRRORING_VERTICAL   = 2'd0;
	localparam logic [1:0] MIRRORING_HORIZONTAL = 2'd1;
	localparam logic [2:0] OP_RSVD_FIRST     = 3'd5;
	localparam logic [2:0] OP_RSVD_LAST      = 3'd7;

	typedef struct packed {
		target_t     tgt;
		logic [18:0] maddr;
		logic        we;
		logic [7:0]  wdata;
		logic        irq;
		logic [1:0]  mir;
	} result_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] addr;
		logic [7:0]  val;
	} bus_item_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] addr;
		logic [7:0]  val;
		logic        typed;
		result_t     fixed;
	} row_t;

	localparam result_t NO_RESULT = '{TGT_NONE, 19'h0, 1'b0, 8'h00, 1'b0, MIRRORING_VERTICAL};

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [2:0]            op;
	logic [ADDR_W-1:0]     address;
	logic [7:0]            value;
	logic                  out_valid;
	logic                  out_stall;
	logic [2:0]            target;
	logic [MAPPED_W-1:0]   mapped_address;
	logic                  write_enable;
	logic [7:0]            write_data;
	logic                  irq;
	logic [1:0]            mirroring;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	// Mirror of the mapper state and configuration.
	logic [6:0] bank_count;
	logic       chr_writable;
	logic       mirror_forced;
	logic [7:0] bank_select;
	logic [7:0] bank_regs [8];
	logic       mirror_bit;
	logic [7:0] irq_latch;
	logic [7:0] irq_count;
	logic       reload_pending;
	logic       irq_enable;

	result_t pending_results [$];
	row_t    smoke_rows [SMOKE_ROWS];
	int      mismatch_count;
	bit      no_idle;
	bit      hold_off_pending;

	banked_cartridge_mapper_irq i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.address        (address),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.target         (target),
		.mapped_address (mapped_address),
		.write_enable   (write_enable),
		.write_data     (write_data),
		.irq            (irq),
		.mirroring      (mirroring),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// Free-running clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Computes the result of one bus item and applies its register and IRQ side effects.
	function automatic result_t translate_access(input logic [2:0] kind,
			input logic [15:0] addr, input logic [7:0] data);
		result_t    r;
		logic [5:0] prg_bank;
		logic [5:0] last_bank;
		logic [5:0] second_bank;
		logic [5:0] r6_bank;
		logic [2:0] chr_win;
		logic [7:0] chr_bank;
		logic [1:0] region;
		r = NO_RESULT;
		region = addr[14:13];
		last_bank = 6'(bank_count - 7'd1);
		second_bank = 6'(bank_count - 7'd2);
		r6_bank = bank_regs[6][5:0];
		case (kind)
		OP_CPU_RD, OP_CPU_WR: begin
			if (addr < RAM_BASE) begin
				r.tgt = TGT_NONE;
			end else if (addr < ROM_BASE) begin
				r.tgt = TGT_PRG_RAM;
				r.maddr = {6'd0, addr[12:0]};
				if (kind == OP_CPU_WR) begin
					r.we = 1'b1;
					r.wdata = data;
				end
			end else if (kind == OP_CPU_RD) begin
				// Four 8 KiB windows; bank select bit 6 swaps the first and third.
				case (region)
				2'd0: prg_bank = bank_select[6] ? second_bank : r6_bank;
				2'd1: prg_bank = bank_regs[7][5:0];
				2'd2: prg_bank = bank_select[6] ? r6_bank : second_bank;
				default: prg_bank = last_bank;
				endcase
				r.tgt = TGT_PRG_ROM;
				r.maddr = {prg_bank, addr[12:0]};
			end else begin
				r.tgt = TGT_REG;
				r.maddr = {3'd0, addr};
				case (region)
				2'd0: begin
					if (addr[0])
						bank_regs[bank_select[2:0]] = data;
					else
						bank_select = data;
				end
				2'd1: begin
					if (!addr[0])
						mirror_bit = data[0];
				end
				2'd2: begin
					if (addr[0])
						reload_pending = 1'b1;
					else
						irq_latch = data;
				end
				default: irq_enable = addr[0];
				endcase
			end
		end
		OP_PPU_RD, OP_PPU_WR: begin
			// Eight 1 KiB windows; bank select bit 7 trades the 2 KiB and 1 KiB halves.
			chr_win = addr[12:10] ^ {bank_select[7], 2'b00};
			if (!chr_win[2]) begin
				chr_bank = bank_regs[chr_win[1]];
				chr_bank = chr_win[0] ? (chr_bank | 8'h01) : (chr_bank & 8'hFE);
			end else begin
				chr_bank = bank_regs[2 + chr_win[1:0]];
			end
			r.tgt = TGT_CHR;
			r.maddr = {1'b0, chr_bank, addr[9:0]};
			if (kind == OP_PPU_WR && chr_writable) begin
				r.we = 1'b1;
				r.wdata = data;
			end
		end
		OP_TICK: begin
			if (irq_count == 8'd0 || reload_pending) begin
				irq_count = irq_latch;
				reload_pending = 1'b0;
			end else begin
				irq_count = irq_count - 8'd1;
			end
			r.irq = (irq_count == 8'd0) && irq_enable;
		end
		default: ;
		endcase
		r.mir = mirror_forced ? MIRRORING_NONE :
			(mirror_bit ? MIRRORING_HORIZONTAL : MIRRORING_VERTICAL);
		return r;
	endfunction

	// Random bus traffic, weighted toward register writes and scanline ticks.
	function automatic bus_item_t draw_bus_item();
		bus_item_t it;
		int        pick;
		pick = $urandom_range(0, 99);
		it.addr = 16'($urandom);
		it.val = 8'($urandom);
		if (pick < 22) begin
			it.op = OP_CPU_RD;
		end else if (pick < 32) begin
			it.op = OP_CPU_WR;
			it.addr[15] = 1'b0;
		end else if (pick < 55) begin
			it.op = OP_CPU_WR;
			it.addr[15] = 1'b1;
			// Small latch values let the counter reach zero often.
			if (it.addr[14:13] == 2'd2 && $urandom_range(0, 1) == 1)
				it.val = 8'($urandom_range(0, 6));
		end else if (pick < 70) begin
			it.op = ($urandom_range(0, 1) == 1) ? OP_PPU_RD : OP_PPU_WR;
		end else if (pick < 96) begin
			it.op = OP_TICK;
		end else begin
			it.op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
		end
		return it;
	endfunction

	// Offers one item after a random gap and records its expected result on transfer.
	task automatic send_item(input logic [2:0] kind, input logic [15:0] addr,
			input logic [7:0] data, input logic typed, input result_t fixed);
		int      gap;
		result_t want;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		address <= addr;
		value <= data;
		do @(posedge clk); while (in_stall);
		want = translate_access(kind, addr, data);
		pending_results.push_back(typed ? fixed : want);
		@(negedge clk);
	endtask

	// Stops offering items and waits until every expected result has arrived.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes all three configuration registers while the block is idle.
	task automatic set_config(input logic [6:0] count, input logic chr_ram,
			input logic mirror_off);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PRG_BANK_COUNT;
		cfg_data <= count;
		@(negedge clk);
		cfg_index <= CFG_CHR_IS_RAM;
		cfg_data <= {6'd0, chr_ram};
		@(negedge clk);
		cfg_index <= CFG_MIRRORING_DISABLED;
		cfg_data <= {6'd0, mirror_off};
		@(negedge clk);
		cfg_we <= 1'b0;
		bank_count = count;
		chr_writable = chr_ram;
		mirror_forced = mirror_off;
	endtask

	// Result side: random stalls per transfer, plus one long hold-off on request.
	initial begin : result_sink
		int hold;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = hold_off_pending ? LONG_HOLD : (no_idle ? 0 : $urandom_range(0, 12));
			hold_off_pending = 1'b0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Compares every result transfer with the oldest expectation.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no expected result waiting");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (target !== want.tgt) begin
					$error("target: expected %0d, got %0d", want.tgt, target);
					mismatch_count++;
				end
				if (mapped_address !== want.maddr) begin
					$error("mapped_address: expected 0x%05h, got 0x%05h", want.maddr,
						mapped_address);
					mismatch_count++;
				end
				if (write_enable !== want.we) begin
					$error("write_enable: expected %0d, got %0d", want.we, write_enable);
					mismatch_count++;
				end
				if (write_data !== want.wdata) begin
					$error("write_data: expected 0x%02h, got 0x%02h", want.wdata, write_data);
					mismatch_count++;
				end
				if (irq !== want.irq) begin
					$error("irq: expected %0d, got %0d", want.irq, irq);
					mismatch_count++;
				end
				if (mirroring !== want.mir) begin
					$error("mirroring: expected %0d, got %0d", want.mir, mirroring);
					mismatch_count++;
				end
			end
		end
	end

	// Main sequence: reset, directed items, then random phases under several settings.
	initial begin : stimulus
		bus_item_t  it;
		logic [6:0] phase_count [NUM_PHASES];
		logic       phase_chr [NUM_PHASES];
		logic       phase_mirror_off [NUM_PHASES];
		int         per_phase;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_CPU_RD;
		address <= '0;
		value <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_PRG_BANK_COUNT;
		cfg_data <= '0;
		mismatch_count = 0;
		no_idle = 1'b0;
		hold_off_pending = 1'b0;
		bank_count = 7'd32;
		chr_writable = 1'b0;
		mirror_forced = 1'b0;
		bank_select = '0;
		foreach (bank_regs[i])
			bank_regs[i] = '0;
		mirror_bit = 1'b0;
		irq_latch = '0;
		irq_count = '0;
		reload_pending = 1'b0;
		irq_enable = 1'b0;

		// Directed items from the reset state: bus edges, register decode and the IRQ counter.
		smoke_rows = '{
			'{OP_CPU_RD, 16'h0000, 8'h00, 1'b1, NO_RESULT},
			'{OP_CPU_WR, 16'h5FFF, 8'hFF, 1'b1, NO_RESULT},
			'{OP_CPU_RD, 16'h6000, 8'h00, 1'b1,
				'{TGT_PRG_RAM, 19'h00000, 1'b0, 8'h00, 1'b0, MIRRORING_VERTICAL}},
			'{OP_CPU_WR, 16'h7FFF, 8'hA5, 1'b1,
				'{TGT_PRG_RAM, 19'h01FFF, 1'b1, 8'hA5, 1'b0, MIRRORING_VERTICAL}},
			'{OP_CPU_RD, 16'h8000, 8'h00, 1'b1,
				'{TGT_PRG_ROM, 19'h00000, 1'b0, 8'h00, 1'b0, MIRRORING_VERTICAL}},
			'{OP_CPU_RD, 16'hFFFF, 8'h00, 1'b1,
				'{TGT_PRG_ROM, 19'h3FFFF, 1'b0, 8'h00, 1'b0, MIRRORING_VERTICAL}},
			'{OP_CPU_RD, 16'hC000, 8'h00, 1'b1,
				'{TGT_PRG_ROM, 19'h3C000, 1'b0, 8'h00, 1'b0, MIRRORING_VERTICAL}},
			'{OP_PPU_RD, 16'h1FFF, 8'h00, 1'b1,
				'{TGT_CHR, 19'h003FF, 1'b0, 8'h00, 1'b0, MIRRORING_VERTICAL}},
			'{OP_PPU_WR, 16'hE000, 8'hFF, 1'b1,
				'{TGT_CHR, 19'h00000, 1'b0, 8'h00, 1'b0, MIRRORING_VERTICAL}},
			'{OP_RSVD_LAST, 16'hFFFF, 8'hFF, 1'b1, NO_RESULT},
			'{OP_TICK, 16'h0000, 8'h00, 1'b1, NO_RESULT},
			'{OP_CPU_WR, 16'h8000, 8'hC7, 1'b1,
				'{TGT_REG, 19'h08000, 1'b0, 8'h00, 1'b0, MIRRORING_VERTICAL}},
			'{OP_CPU_WR, 16'h8001, 8'hFF, 1'b1,
				'{TGT_REG, 19'h08001, 1'b0, 8'h00, 1'b0, MIRRORING_VERTICAL}},
			'{OP_CPU_RD, 16'h8000, 8'h00, 1'b0, NO_RESULT},
			'{OP_PPU_RD, 16'h0000, 8'h00, 1'b0, NO_RESULT},
			'{OP_CPU_WR, 16'h8000, 8'h06, 1'b0, NO_RESULT},
			'{OP_CPU_WR, 16'h9FFF, 8'h3F, 1'b0, NO_RESULT},
			'{OP_CPU_RD, 16'hA123, 8'h00, 1'b0, NO_RESULT},
			'{OP_CPU_WR, 16'hA000, 8'h01, 1'b1,
				'{TGT_REG, 19'h0A000, 1'b0, 8'h00, 1'b0, MIRRORING_HORIZONTAL}},
			'{OP_CPU_WR, 16'hBFFF, 8'h00, 1'b1,
				'{TGT_REG, 19'h0BFFF, 1'b0, 8'h00, 1'b0, MIRRORING_HORIZONTAL}},
			'{OP_CPU_WR, 16'hC000, 8'h02, 1'b0, NO_RESULT},
			'{OP_CPU_WR, 16'hC001, 8'h00, 1'b0, NO_RESULT},
			'{OP_CPU_WR, 16'hE001, 8'h00, 1'b0, NO_RESULT},
			'{OP_TICK, 16'h0000, 8'h00, 1'b0, NO_RESULT},
			'{OP_TICK, 16'hFFFF, 8'hFF, 1'b0, NO_RESULT},
			'{OP_TICK, 16'h0000, 8'h00, 1'b0, NO_RESULT}
		};

		// Settings per random phase: tiny, extreme and out-of-range bank counts included.
		phase_count = '{7'd2, 7'd64, 7'd1, 7'd0, 7'd127, 7'($urandom_range(2, 64)),
			7'($urandom_range(2, 64))};
		phase_chr = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom), 1'($urandom)};
		phase_mirror_off = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'($urandom), 1'($urandom)};
		per_phase = RANDOM_ITEMS / NUM_PHASES;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (smoke_rows[i])
			send_item(smoke_rows[i].op, smoke_rows[i].addr, smoke_rows[i].val,
				smoke_rows[i].typed, smoke_rows[i].fixed);
		drain_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_config(phase_count[p], phase_chr[p], phase_mirror_off[p]);
			for (int n = 0; n < per_phase; n++) begin
				// Alternate stretches with and without idle cycles.
				if (n % 48 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				if (p == 2 && n == 60)
					hold_off_pending = 1'b1;
				it = draw_bus_item();
				send_item(it.op, it.addr, it.val, 1'b0, NO_RESULT);
			end
			drain_results();
		end

		if (mismatch_count == 0)
			$display("[banked_cartridge_mapper_irq] OK");
		else
			$display("[banked_cartridge_mapper_irq] ERROR");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin : watchdog
		#2_000_000;
		$display("[banked_cartridge_mapper_irq] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bcm_pkg.sv
rtl/banked_cartridge_mapper_irq.sv
dv/banked_cartridge_mapper_irq_tb.sv
